[hdl/swdl_pkg.sv]
// shared constants, types and request codes for the sliding window dose limiter
package swdl_pkg;

    // ring geometry
    localparam int RING_DEPTH = 16;
    localparam int HALF_DEPTH = RING_DEPTH / 2;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;

    // field and accumulator widths
    localparam int COUNT_W = 16;
    localparam int AMT_W   = 16;
    localparam int LIMIT_W = 20;
    localparam int TOTAL_W = 20;
    localparam int SUM_W   = $clog2(65535 * (HALF_DEPTH + 1) + 1);
    localparam int WIDE_W  = ((SUM_W > TOTAL_W) ? SUM_W : TOTAL_W) + 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // request kinds
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_RECORD = 2'd1;
    localparam logic [1:0] REQ_CHECK  = 2'd2;

    typedef logic [PTR_W-1:0] ptr_t;

    // one access to the ring memory
    typedef struct packed {
        logic                wr_en;
        logic                rd_en;
        ptr_t                addr;
        logic [COUNT_W-1:0]  wr_data;
    } ring_req_t;

endpackage

[hdl/sliding_window_dose_limiter_top.sv]
// Sliding window dose limiter top: ticks and records are taken back to back while idle.
// A dose check walks RING_DEPTH/2 ring entries (8 at depth 16), one ring read per cycle
// through the single registered read port of the ring memory and one adder.
// The result sits in an output register, so the next item is taken while it waits.
// Reset (rst_n, async, active low) zeroes the ring through per-entry valid bits,
// the head pointer, the running count and dose_limit; no clearing pass is needed.
module sliding_window_dose_limiter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // req_type
    input  logic [15:0] s_tdata,   // amount
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data,  // dose_limit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // dose_ok, window_total[20:1], zero pad
);
    import swdl_pkg::*;

    ring_req_t          ring_req;
    logic [COUNT_W-1:0] ring_rd_data;

    // sequencer
    swdl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .ring_req     (ring_req),
        .ring_rd_data (ring_rd_data)
    );

    // interval ring
    swdl_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ring_req),
        .rd_data (ring_rd_data)
    );

endmodule

[hdl/swdl_ring.sv]
// interval ring memory with registered read and per-entry valid bits
module swdl_ring (
    input  logic                        clk,
    input  logic                        rst_n,
    input  swdl_pkg::ring_req_t         req,
    output logic [swdl_pkg::COUNT_W-1:0] rd_data
);
    import swdl_pkg::*;

    logic [COUNT_W-1:0]    mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] vld_reg;
    logic [COUNT_W-1:0]    rd_data_reg;
    logic                  rd_vld_reg;

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    // valid bits, cleared at reset so unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

[hdl/swdl_ctrl.sv]
// request sequencer: tick, record and the half-ring walk for a dose check
module swdl_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [1:0]                    s_tuser,   // req_type
    input  logic [15:0]                   s_tdata,   // amount
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [swdl_pkg::LIMIT_W-1:0]  cfg_data,  // dose_limit
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // dose_ok, window_total, zero pad
    output swdl_pkg::ring_req_t           ring_req,
    input  logic [swdl_pkg::COUNT_W-1:0]  ring_rd_data
);
    import swdl_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_LAST = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]         state_reg,   state_next;
    ptr_t               head_reg,    head_next;
    ptr_t               addr_reg,    addr_next;
    logic [CNT_W-1:0]   cnt_reg,     cnt_next;
    logic [COUNT_W-1:0] run_reg,     run_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [AMT_W-1:0]   amt_reg,     amt_next;
    logic [SUM_W-1:0]   acc_reg,     acc_next;
    logic               pend_reg,    pend_next;
    logic               m_vld_reg,   m_vld_next;
    logic               ok_reg,      ok_next;
    logic [TOTAL_W-1:0] total_reg,   total_next;

    logic               in_acc;
    logic               out_free;
    logic [COUNT_W:0]   run_sum;
    logic [WIDE_W-1:0]  acc_wide;
    ptr_t               head_prev;
    ptr_t               addr_prev;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_vld_reg || m_tready;

    assign run_sum   = {1'b0, run_reg} + {1'b0, s_tdata};
    assign acc_wide  = WIDE_W'(acc_reg);
    assign head_prev = (head_reg == '0) ? ptr_t'(RING_DEPTH - 1) : head_reg - 1'b1;
    assign addr_prev = (addr_reg == '0) ? ptr_t'(RING_DEPTH - 1) : addr_reg - 1'b1;

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        amt_next   = amt_reg;
        acc_next   = acc_reg;
        pend_next  = 1'b0;
        m_vld_next = m_vld_reg;
        ok_next    = ok_reg;
        total_next = total_reg;
        ring_req   = '0;

        // output register drains independently
        if (m_vld_reg && m_tready)
        begin
            m_vld_next = 1'b0;
        end

        // accumulate read data that arrives in the cycle after its read
        if (pend_reg)
        begin
            acc_next = acc_reg + SUM_W'(ring_rd_data);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (s_tuser)
                        REQ_TICK:
                        begin
                            ring_req.wr_en   = 1'b1;
                            ring_req.addr    = head_reg;
                            ring_req.wr_data = run_reg;
                            head_next = (head_reg == ptr_t'(RING_DEPTH - 1)) ? '0
                                                                             : head_reg + 1'b1;
                            run_next  = '0;
                        end
                        REQ_RECORD:
                        begin
                            run_next = run_sum[COUNT_W] ? COUNT_MAX : run_sum[COUNT_W-1:0];
                        end
                        REQ_CHECK:
                        begin
                            amt_next   = s_tdata;
                            acc_next   = SUM_W'(run_reg);
                            addr_next  = head_prev;
                            cnt_next   = '0;
                            state_next = ST_SUM;
                        end
                        default:
                        begin
                            // unused code, ignored
                        end
                    endcase
                end
            end
            ST_SUM:
            begin
                ring_req.rd_en = 1'b1;
                ring_req.addr  = addr_reg;
                pend_next      = 1'b1;
                addr_next      = addr_prev;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(HALF_DEPTH - 1))
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_vld_next = 1'b1;
                    ok_next    = (acc_wide + WIDE_W'(amt_reg)) < WIDE_W'(limit_reg);
                    total_next = (acc_wide > WIDE_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                                 : acc_wide[TOTAL_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            run_reg   <= '0;
            limit_reg <= '0;
            pend_reg  <= 1'b0;
            m_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            run_reg   <= run_next;
            pend_reg  <= pend_next;
            m_vld_reg <= m_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        cnt_reg   <= cnt_next;
        amt_reg   <= amt_next;
        acc_reg   <= acc_next;
        ok_reg    <= ok_next;
        total_reg <= total_next;
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {3'b000, total_reg, ok_reg};

endmodule

[dv/swdl_dose_monitor.sv]
// dose limiter monitor: watches every channel, predicts each dose check and compares results
module swdl_dose_monitor (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [1:0]                   s_tuser,   // req_type
    input  logic [swdl_pkg::AMT_W-1:0]   s_tdata,   // amount
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [swdl_pkg::LIMIT_W-1:0] cfg_data,  // dose_limit
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [23:0]                  m_tdata,   // dose_ok, window_total, zero pad
    output int                           fail_count,
    output int                           pending
);
    import swdl_pkg::*;

    typedef struct packed {
        logic               dose_ok;
        logic [TOTAL_W-1:0] window_total;
    } dose_verdict_t;

    // shadow of the block state
    logic [COUNT_W-1:0] step_ring [RING_DEPTH];
    int unsigned        head_slot;
    logic [COUNT_W-1:0] running_steps;
    logic [LIMIT_W-1:0] limit_now;
    dose_verdict_t      verdict_q [$];

    // half-ring window just below the head, plus the running interval
    function automatic dose_verdict_t assess_dose(input logic [AMT_W-1:0] dose);
        int unsigned   sum;
        int unsigned   pos;
        dose_verdict_t v;
        sum = 32'(running_steps);
        for (int k = 0; k < HALF_DEPTH; k++)
        begin
            pos = (head_slot + 2 * RING_DEPTH - 1 - k) % RING_DEPTH;
            sum += 32'(step_ring[pos[PTR_W-1:0]]);
        end
        v.window_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        v.dose_ok      = ((sum + 32'(dose)) < 32'(limit_now));
        return v;
    endfunction

    task automatic flag_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
        fail_count++;
        if (fail_count <= 10)
            $display("monitor: %s mismatch, expected %0d, got %0d", field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dose_verdict_t want;
        logic [19:0]   sat;
        if (!rst_n)
        begin
            step_ring     = '{default: '0};
            head_slot     = 0;
            running_steps = '0;
            limit_now     = '0;
            fail_count    = 0;
            verdict_q.delete();
            pending <= 0;
        end
        else
        begin
            // result transaction, compared before this edge's input is predicted
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                    flag_mismatch("unexpected result, window_total", 0, m_tdata[20:1]);
                else
                begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want.dose_ok)
                        flag_mismatch("dose_ok", want.dose_ok, m_tdata[0]);
                    if (m_tdata[20:1] !== want.window_total)
                        flag_mismatch("window_total", want.window_total, m_tdata[20:1]);
                    if (m_tdata[23:21] !== 3'b000)
                        flag_mismatch("pad bits", 0, m_tdata[23:21]);
                end
            end

            // limit register write
            if (cfg_valid && cfg_ready)
                limit_now = cfg_data;

            // request transaction
            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    REQ_TICK:
                    begin
                        if (head_slot >= RING_DEPTH)
                            head_slot = 0;
                        step_ring[head_slot[PTR_W-1:0]] = running_steps;
                        head_slot++;
                        running_steps = '0;
                    end
                    REQ_RECORD:
                    begin
                        sat = 20'(running_steps) + 20'(s_tdata);
                        running_steps = (sat > 20'(COUNT_MAX)) ? COUNT_MAX
                                                               : sat[COUNT_W-1:0];
                    end
                    REQ_CHECK:
                        verdict_q.push_back(assess_dose(s_tdata));
                    default:
                        ;
                endcase
            end

            pending <= verdict_q.size();
        end
    end

endmodule

[dv/sliding_window_dose_limiter_top_test.sv]
// testbench top for the sliding window dose limiter: stimulus, idling and verdict
module sliding_window_dose_limiter_top_test;
    import swdl_pkg::*;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         SETTLE_TIME  = 2 * HALF_DEPTH + 8;
    localparam int         PHASE_COUNT  = 8;
    localparam int         PHASE_ITEMS  = 100;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [1:0]         s_tuser;   // req_type
    logic [AMT_W-1:0]   s_tdata;   // amount
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data;  // dose_limit
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [23:0]        m_tdata;   // dose_ok, window_total, zero pad
    int                 fail_count;
    int                 pending;

    int cycles = 0;
    int ready_hold = 0;
    bit calm = 1'b0;
    int n_tick = 0;
    int n_record = 0;
    int n_check = 0;
    int n_unused = 0;
    int n_limit = 0;

    always #2 clk = ~clk;

    sliding_window_dose_limiter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    swdl_dose_monitor u_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side stalls in random bursts
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            m_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 4) == 0)
        begin
            ready_hold = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // one request transaction, with an occasional gap ahead of it
    task automatic send_request(input logic [1:0] kind, input logic [AMT_W-1:0] amount);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= amount;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        case (kind)
            REQ_TICK:   n_tick++;
            REQ_RECORD: n_record++;
            REQ_CHECK:  n_check++;
            default:    n_unused++;
        endcase
    endtask

    // hold the sender until every dose check has answered, then let the block settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_TIME) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        n_limit++;
    endtask

    // mostly records and checks, some ticks, a few unused codes
    task automatic random_request();
        int unsigned      pick;
        logic [AMT_W-1:0] amount;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
            amount = AMT_W'($urandom_range(0, 65535));
        else
            amount = AMT_W'($urandom_range(0, 3000));
        if (pick < 20)
            send_request(REQ_TICK, amount);
        else if (pick < 60)
            send_request(REQ_RECORD, (pick < 22) ? 16'hFFFF : amount);
        else if (pick < 95)
            send_request(REQ_CHECK, amount);
        else
            send_request(REQ_UNUSED, amount);
    endtask

    initial
    begin
        logic [LIMIT_W-1:0] lim;
        s_tvalid  <= 1'b0;
        s_tuser   <= REQ_TICK;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // limit still zero from reset, head at zero so the window wraps to the top
        send_request(REQ_CHECK, 16'h0000);
        send_request(REQ_RECORD, 16'hFFFF);
        send_request(REQ_RECORD, 16'hFFFF);   // running count saturates
        send_request(REQ_CHECK, 16'hFFFF);
        send_request(REQ_TICK, 16'h0000);
        send_request(REQ_RECORD, 16'd1234);
        send_request(REQ_UNUSED, 16'hFFFF);   // ignored
        send_request(REQ_CHECK, 16'h0000);

        // window now 65535 + 1234 = 66769: hit the strict comparison on both sides
        write_limit(20'd66869);
        send_request(REQ_CHECK, 16'd99);
        send_request(REQ_CHECK, 16'd100);
        send_request(REQ_CHECK, 16'd101);

        write_limit(20'hFFFFF);
        send_request(REQ_CHECK, 16'hFFFF);
        send_request(REQ_TICK, 16'hFFFF);
        send_request(REQ_RECORD, 16'h5555);
        send_request(REQ_RECORD, 16'hAAAA);
        send_request(REQ_TICK, 16'h0000);
        send_request(REQ_CHECK, 16'hAAAA);
        send_request(REQ_TICK, 16'h0000);
        send_request(REQ_CHECK, 16'h5555);

        // random phases, each under its own limit; the last one without idling
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       lim = 20'h00000;
                1:       lim = 20'hFFFFF;
                2:       lim = LIMIT_W'($urandom_range(20000, 120000));
                default: lim = LIMIT_W'($urandom_range(1, 400000));
            endcase
            write_limit(lim);
            calm = (p == PHASE_COUNT - 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                random_request();
                if (p == 3 && i == PHASE_ITEMS / 2)
                    drain_results();
            end
        end
        drain_results();

        $display("tb: ran %0d ticks, %0d records, %0d dose checks and %0d unused codes",
                 n_tick, n_record, n_check, n_unused);
        $display("tb: across %0d limit settings including zero and full scale", n_limit);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sliding_window_dose_limiter_top.f]
hdl/swdl_pkg.sv
hdl/swdl_ring.sv
hdl/swdl_ctrl.sv
hdl/sliding_window_dose_limiter_top.sv
dv/swdl_dose_monitor.sv
dv/sliding_window_dose_limiter_top_test.sv
